>>> src/psp_pkg.sv
`timescale 1ns / 1ps

package psp_pkg;

    // Build-time limits of the packer.
    localparam int MAX_SLOTS       = 4;
    localparam int MAX_SAMPLE_BITS = 32;
    localparam int BIT_LIMIT       = (MAX_SAMPLE_BITS < 32) ? MAX_SAMPLE_BITS : 32;

    localparam logic [5:0] BIT_LIMIT_W     = 6'(BIT_LIMIT);
    localparam logic [1:0] LAST_SLOT_LIMIT = 2'(MAX_SLOTS - 1);

    // Operand width of the shared signed multiplier.
    localparam int MUL_W = 33;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_FORMAT     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOT_OFFSETS      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_CONVERSION_RANGE  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PLANE_START       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_LINE_STRIDE       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_STRIDE_BITS = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_GEOMETRY    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_INTERLEAVE_MODE   = 3'd7;

    // Interleave modes.
    localparam logic [1:0] ILV_NONE       = 2'd0;
    localparam logic [1:0] ILV_EVEN_FIRST = 2'd1;
    localparam logic [1:0] ILV_ODD_FIRST  = 2'd2;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_N    = 7'b0000010,
        ST_ADDR = 7'b0000100,
        ST_OFFS = 7'b0001000,
        ST_LO   = 7'b0010000,
        ST_HI   = 7'b0100000,
        ST_FIN  = 7'b1000000
    } psp_state_t;

endpackage

>>> src/pixel_sample_packer_top.sv
`timescale 1ns / 1ps

// Pixel sample packer: each accepted sample request yields one write
// descriptor (line address, bit offset, bit count, packed bits, end of frame).
// An item is accepted in the idle state and then makes five passes through
// the single shared 33x33 signed multiplier (range mapping, line address,
// bit offset, low and high halves of the scaling); a final state rounds,
// saturates and loads the output register, and holds for as long as the
// previous descriptor has not been taken. The input is not ready while an
// item is in flight. The output register is separate, so the next request
// is accepted while a finished descriptor still waits to be taken.
module pixel_sample_packer_top
    import psp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [16:0]            s_sample_value,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [31:0]            m_line_address,
    output logic [31:0]            m_bit_offset,
    output logic [5:0]             m_bit_count,
    output logic [31:0]            m_packed_bits,
    output logic                   m_frame_done
);

    // Configuration registers.
    logic [13:0] sample_format_reg;
    logic [63:0] slot_offsets_reg;
    logic [33:0] conversion_range_reg;
    logic [31:0] plane_start_reg;
    logic [20:0] line_stride_reg;
    logic [15:0] block_stride_bits_reg;
    logic [31:0] frame_geometry_reg;
    logic [1:0]  interleave_mode_reg;

    // Position counters.
    logic [1:0]  slot_index_reg,   slot_index_next;
    logic [15:0] block_column_reg, block_column_next;
    logic [15:0] block_row_reg,    block_row_next;

    psp_state_t  state_reg, state_next;

    logic [16:0] sample_reg;
    logic [31:0] maxv_reg;
    logic signed [35:0] n_reg, n_next;
    logic [31:0] addr_reg, addr_next;
    logic [31:0] offs_reg, offs_next;
    logic [32:0] frac_reg, frac_next;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod_reg;

    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_line_address_reg;
    logic [31:0] m_bit_offset_reg;
    logic [5:0]  m_bit_count_reg;
    logic [31:0] m_packed_bits_reg;
    logic        m_frame_done_reg;

    // Effective format.
    logic [5:0]  ib_eff, fb_eff, fb_room;
    logic [32:0] maxv_wide;
    logic [1:0]  slot_last_idx;
    logic        last_slot, last_col, last_row, frame_end;
    logic [15:0] per_line, lines;

    logic [16:0] range_lo, range_hi;
    logic [17:0] range_diff;
    logic [16:0] stored_line;
    logic [15:0] slot_offset;
    logic [64:0] frac_sum;
    logic [35:0] q_sum;
    logic [31:0] packed_value;
    logic        load_out;

    assign range_lo = conversion_range_reg[16:0];
    assign range_hi = conversion_range_reg[33:17];
    assign range_diff = {1'b0, range_hi} - {1'b0, range_lo};
    assign per_line = frame_geometry_reg[15:0];
    assign lines    = frame_geometry_reg[31:16];

    always_comb begin
        ib_eff = (sample_format_reg[5:0] > BIT_LIMIT_W) ? BIT_LIMIT_W : sample_format_reg[5:0];
        fb_room = BIT_LIMIT_W - ib_eff;
        fb_eff = (sample_format_reg[11:6] > fb_room) ? fb_room : sample_format_reg[11:6];
        maxv_wide = ((33'd1 << ib_eff) - 33'd1) << fb_eff;
        slot_last_idx = (sample_format_reg[13:12] > LAST_SLOT_LIMIT) ? LAST_SLOT_LIMIT
                                                                     : sample_format_reg[13:12];
    end

    assign last_slot = slot_index_reg >= slot_last_idx;
    assign last_col  = ({1'b0, block_column_reg} + 17'd1) >= {1'b0, per_line};
    assign last_row  = ({1'b0, block_row_reg} + 17'd1) >= {1'b0, lines};
    assign frame_end = last_slot && last_col && last_row;

    // Destination line after interleaving; an unused mode code behaves as none.
    always_comb begin
        unique case (interleave_mode_reg)
            ILV_EVEN_FIRST: begin
                stored_line = block_row_reg[0]
                    ? (({1'b0, lines} + 17'd1) >> 1) + {2'b0, block_row_reg[15:1]}
                    : {2'b0, block_row_reg[15:1]};
            end
            ILV_ODD_FIRST: begin
                stored_line = block_row_reg[0]
                    ? {2'b0, block_row_reg[15:1]}
                    : {2'b0, lines[15:1]} + {2'b0, block_row_reg[15:1]};
            end
            default: stored_line = {1'b0, block_row_reg};
        endcase
    end

    assign slot_offset = slot_offsets_reg[16*slot_index_reg +: 16];

    // Operand selection for the shared multiplier. The high half keeps its
    // operands while the result waits, so the product stays valid.
    always_comb begin
        unique case (state_reg)
            ST_N: begin
                mul_a = MUL_W'(signed'({1'b0, sample_reg}));
                mul_b = MUL_W'(signed'(range_diff));
            end
            ST_ADDR: begin
                mul_a = MUL_W'(signed'({1'b0, stored_line}));
                mul_b = MUL_W'(signed'(line_stride_reg));
            end
            ST_OFFS: begin
                mul_a = MUL_W'(signed'({1'b0, block_column_reg}));
                mul_b = MUL_W'(signed'({1'b0, block_stride_bits_reg}));
            end
            ST_LO: begin
                mul_a = signed'({1'b0, n_reg[31:0]});
                mul_b = signed'({1'b0, maxv_reg});
            end
            ST_HI, ST_FIN: begin
                mul_a = MUL_W'(signed'({1'b0, n_reg[35:32]}));
                mul_b = signed'({1'b0, maxv_reg});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign frac_sum = {1'b0, prod_reg[63:0]} + 65'h0_8000_0000;
    assign q_sum    = prod_reg[35:0] + {3'b0, frac_reg};

    // Round-half-up result, saturated to the format maximum; zero when n <= 0.
    always_comb begin
        if (n_reg[35] || (n_reg == '0) || (maxv_reg == '0)) begin
            packed_value = '0;
        end else if (q_sum > {4'b0, maxv_reg}) begin
            packed_value = maxv_reg;
        end else begin
            packed_value = q_sum[31:0];
        end
    end

    assign load_out = (state_reg == ST_FIN) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        addr_next  = addr_reg;
        offs_next  = offs_reg;
        frac_next  = frac_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_N;
                end
            end
            ST_N: state_next = ST_ADDR;
            ST_ADDR: begin
                n_next = signed'({3'b0, range_lo, 16'b0} + prod_reg[35:0]);
                state_next = ST_OFFS;
            end
            ST_OFFS: begin
                addr_next = plane_start_reg + prod_reg[31:0];
                state_next = ST_LO;
            end
            ST_LO: begin
                offs_next = prod_reg[31:0] + {16'b0, slot_offset};
                state_next = ST_HI;
            end
            ST_HI: begin
                frac_next = frac_sum[64:32];
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Position counters advance as each descriptor is loaded.
    always_comb begin
        slot_index_next   = slot_index_reg;
        block_column_next = block_column_reg;
        block_row_next    = block_row_reg;
        if (load_out) begin
            if (!last_slot) begin
                slot_index_next = slot_index_reg + 2'd1;
            end else begin
                slot_index_next = '0;
                if (!last_col) begin
                    block_column_next = block_column_reg + 16'd1;
                end else begin
                    block_column_next = '0;
                    block_row_next = last_row ? '0 : block_row_reg + 16'd1;
                end
            end
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            slot_index_reg   <= '0;
            block_column_reg <= '0;
            block_row_reg    <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg        <= state_next;
            slot_index_reg   <= slot_index_next;
            block_column_reg <= block_column_next;
            block_row_reg    <= block_row_next;
            m_valid_reg      <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_format_reg     <= 14'd8;
            slot_offsets_reg      <= '0;
            conversion_range_reg  <= 34'h1_0000_0000;
            plane_start_reg       <= '0;
            line_stride_reg       <= '0;
            block_stride_bits_reg <= 16'd8;
            frame_geometry_reg    <= '0;
            interleave_mode_reg   <= ILV_NONE;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SAMPLE_FORMAT:     sample_format_reg     <= cfg_wdata[13:0];
                REG_SLOT_OFFSETS:      slot_offsets_reg      <= cfg_wdata;
                REG_CONVERSION_RANGE:  conversion_range_reg  <= cfg_wdata[33:0];
                REG_PLANE_START:       plane_start_reg       <= cfg_wdata[31:0];
                REG_LINE_STRIDE:       line_stride_reg       <= cfg_wdata[20:0];
                REG_BLOCK_STRIDE_BITS: block_stride_bits_reg <= cfg_wdata[15:0];
                REG_FRAME_GEOMETRY:    frame_geometry_reg    <= cfg_wdata[31:0];
                REG_INTERLEAVE_MODE:   interleave_mode_reg   <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        n_reg    <= n_next;
        addr_reg <= addr_next;
        offs_reg <= offs_next;
        frac_reg <= frac_next;
        if ((state_reg == ST_IDLE) && s_valid) begin
            // Values above one are taken as one.
            sample_reg <= (s_sample_value > 17'h10000) ? 17'h10000 : s_sample_value;
        end
        if (state_reg == ST_N) begin
            maxv_reg <= maxv_wide[31:0];
        end
        if (load_out) begin
            m_line_address_reg <= addr_reg;
            m_bit_offset_reg   <= offs_reg;
            m_bit_count_reg    <= ib_eff + fb_eff;
            m_packed_bits_reg  <= packed_value;
            m_frame_done_reg   <= frame_end;
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_line_address = m_line_address_reg;
    assign m_bit_offset   = m_bit_offset_reg;
    assign m_bit_count    = m_bit_count_reg;
    assign m_packed_bits  = m_packed_bits_reg;
    assign m_frame_done   = m_frame_done_reg;

`ifndef ASSERT_OFF
    // A request occupies the sequencer, so no second request follows at once.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while the sequencer was busy");

    // The packed value never has bits above the bit count.
    a_bits_fit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_bit_count < 6'd32)) |-> ((m_packed_bits >> m_bit_count) == 32'd0))
        else $error("packed bits exceed the bit count");

    // The bit count never exceeds the output width.
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_bit_count <= 6'd32))
        else $error("bit count above 32");
`endif

endmodule

>>> tb/sv/pixel_sample_packer_top_tb.sv
`timescale 1ns / 1ps

module pixel_sample_packer_top_tb
    import psp_pkg::*;
();

    localparam int TARGET_SAMPLES = 1850;
    localparam int DRAIN_CYCLES   = 12;
    localparam int LONG_STALL     = 200;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [31:0] line_address;
        logic [31:0] bit_offset;
        logic [5:0]  bit_count;
        logic [31:0] packed_bits;
        logic        frame_done;
    } write_desc_t;

    logic                   aclk;
    logic                   aresetn        = 1'b0;
    logic                   cfg_wr_en      = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata      = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [16:0]            s_sample_value = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [31:0]            m_line_address;
    logic [31:0]            m_bit_offset;
    logic [5:0]             m_bit_count;
    logic [31:0]            m_packed_bits;
    logic                   m_frame_done;

    // Shadow copy of the register file and the traversal counters.
    logic [13:0] fmt_reg      = 14'd8;
    logic [63:0] slot_offs_reg = '0;
    logic [33:0] range_reg    = 34'h1_0000_0000;
    logic [31:0] plane_reg    = '0;
    logic [20:0] lstride_reg  = '0;
    logic [15:0] bstride_reg  = 16'd8;
    logic [31:0] geom_reg     = '0;
    logic [1:0]  ilv_reg      = ILV_NONE;
    logic [1:0]  slot_idx     = '0;
    logic [15:0] blk_col      = '0;
    logic [15:0] blk_row      = '0;

    logic [16:0] sample_backlog[$];
    write_desc_t expected_writes[$];
    write_desc_t head_write;

    int  mismatches     = 0;
    int  queued_samples = 0;
    int  send_gap       = 0;
    int  ready_hold     = 0;
    int  ready_draw;
    int  stall_left     = 0;
    int  stall_requests = 0;
    int  stall_served   = 0;
    int  idle_cycles    = 0;
    bit  sender_eager   = 1'b0;
    bit  sink_eager     = 1'b0;

    pixel_sample_packer_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_value (s_sample_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_address (m_line_address),
        .m_bit_offset   (m_bit_offset),
        .m_bit_count    (m_bit_count),
        .m_packed_bits  (m_packed_bits),
        .m_frame_done   (m_frame_done)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Computes the descriptor for one sample and advances the slot, column
    // and row counters.
    function automatic write_desc_t pack_sample(input logic [16:0] sample);
        write_desc_t d;
        int unsigned ib, fb, slots, per_line, lines;
        logic [63:0] maxv, stride, row, height, line, num_u, q;
        longint      lo, hi, vq, num;
        bit          last_slot, last_col, last_row;
        ib    = fmt_reg[5:0];
        fb    = fmt_reg[11:6];
        slots = fmt_reg[13:12] + 1;
        if (ib > BIT_LIMIT) ib = BIT_LIMIT;
        if (fb > BIT_LIMIT - ib) fb = BIT_LIMIT - ib;
        if (slots > MAX_SLOTS) slots = MAX_SLOTS;
        maxv = ((64'd1 << ib) - 64'd1) << fb;

        per_line = geom_reg[15:0];
        lines    = geom_reg[31:16];
        stride   = {{43{lstride_reg[20]}}, lstride_reg};
        row      = 64'(blk_row);
        height   = 64'(lines);
        case (ilv_reg)
            ILV_EVEN_FIRST: begin
                line = row[0] ? (height + 64'd1) / 64'd2 + row / 64'd2 : row / 64'd2;
            end
            ILV_ODD_FIRST: begin
                line = row[0] ? row / 64'd2 : height / 64'd2 + row / 64'd2;
            end
            default: begin
                line = row;
            end
        endcase
        d.line_address = 32'(64'(plane_reg) + line * stride);
        d.bit_offset   = 32'(64'(blk_col) * 64'(bstride_reg)
                             + 64'(slot_offs_reg[16*slot_idx +: 16]));
        d.bit_count    = 6'(ib + fb);

        // Exact fixed-point form of lo + v * (hi - lo), scaled by maxv and
        // rounded half up; only the positive side can produce a nonzero code.
        vq = sample;
        if (vq > 65536) vq = 65536;
        lo  = range_reg[16:0];
        hi  = range_reg[33:17];
        num = lo * 65536 + vq * (hi - lo);
        if (num <= 0 || maxv == 0) begin
            q = '0;
        end else begin
            num_u = num;
            q = (num_u >> 32) * maxv + ((64'(num_u[31:0]) * maxv + 64'h8000_0000) >> 32);
            if (q > maxv) q = maxv;
        end
        d.packed_bits = q[31:0];

        last_slot = 32'(slot_idx) + 32'd1 >= slots;
        last_col  = 32'(blk_col) + 32'd1 >= per_line;
        last_row  = 32'(blk_row) + 32'd1 >= lines;
        d.frame_done = last_slot && last_col && last_row;

        if (!last_slot) begin
            slot_idx = slot_idx + 2'd1;
        end else begin
            slot_idx = '0;
            if (!last_col) begin
                blk_col = blk_col + 16'd1;
            end else begin
                blk_col = '0;
                blk_row = last_row ? 16'd0 : blk_row + 16'd1;
            end
        end
        return d;
    endfunction

    function automatic logic [63:0] random_reg_value(input logic [CFG_INDEX_W-1:0] idx);
        int unsigned pick;
        pick = $urandom_range(0, 7);
        // Now and then the whole word is random, upper bits included.
        if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
        case (idx)
            REG_SAMPLE_FORMAT: begin
                case (pick)
                    0: return 64'($urandom_range(0, 16383));
                    1: return {50'd0, 2'($urandom), 6'd0, 6'd32};
                    2: return {50'd0, 2'($urandom), 6'($urandom), 6'($urandom_range(33, 63))};
                    default: return {50'd0, 2'($urandom), 6'($urandom_range(0, 6)),
                                     6'($urandom_range(1, 16))};
                endcase
            end
            REG_SLOT_OFFSETS: begin
                case (pick)
                    0: return {$urandom, $urandom};
                    1: return '1;
                    default: return {16'($urandom_range(0, 255)), 16'($urandom_range(0, 255)),
                                     16'($urandom_range(0, 255)), 16'($urandom_range(0, 255))};
                endcase
            end
            REG_CONVERSION_RANGE: begin
                case (pick)
                    0: return {30'd0, 17'd65536, 17'd0};
                    1: return {30'd0, 2'($urandom), $urandom};
                    2: return {30'd0, 17'($urandom_range(0, 16384)),
                               17'($urandom_range(49152, 65536))};
                    default: return {30'd0, 17'($urandom_range(0, 65536)),
                                     17'($urandom_range(0, 65536))};
                endcase
            end
            REG_PLANE_START: begin
                case (pick)
                    0: return 64'd0;
                    1: return 64'hFFFF_FFFF;
                    default: return 64'($urandom);
                endcase
            end
            REG_LINE_STRIDE: begin
                case (pick)
                    0: return 64'h10_0000;
                    1: return 64'h0F_FFFF;
                    2: return 64'($urandom_range(0, 21'h1F_FFFF));
                    default: return 64'(21'($urandom_range(0, 8191) - 4096));
                endcase
            end
            REG_BLOCK_STRIDE_BITS: begin
                case (pick)
                    0: return 64'd65535;
                    1: return 64'd0;
                    default: return 64'($urandom_range(1, 64));
                endcase
            end
            REG_FRAME_GEOMETRY: begin
                case (pick)
                    0: return 64'($urandom);
                    1: return 64'd0;
                    default: return {32'd0, 16'($urandom_range(1, 6)), 16'($urandom_range(1, 5))};
                endcase
            end
            default: begin
                return 64'($urandom_range(0, 3));
            end
        endcase
    endfunction

    function automatic logic [16:0] random_sample();
        case ($urandom_range(0, 9))
            0: return 17'd0;
            1: return 17'd65536;
            2: return 17'($urandom_range(65537, 131071));
            3: return 17'($urandom_range(0, 131071));
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_SAMPLE_FORMAT:     fmt_reg       = data[13:0];
            REG_SLOT_OFFSETS:      slot_offs_reg = data;
            REG_CONVERSION_RANGE:  range_reg     = data[33:0];
            REG_PLANE_START:       plane_reg     = data[31:0];
            REG_LINE_STRIDE:       lstride_reg   = data[20:0];
            REG_BLOCK_STRIDE_BITS: bstride_reg   = data[15:0];
            REG_FRAME_GEOMETRY:    geom_reg      = data[31:0];
            REG_INTERLEAVE_MODE:   ilv_reg       = data[1:0];
            default: ;
        endcase
    endtask

    task automatic close_writes();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_sample(input logic [16:0] sample);
        sample_backlog = {sample_backlog, sample};
        queued_samples++;
    endtask

    // Returns once every request is taken and every descriptor has come back,
    // leaving the pipeline time to go quiet. The check runs on the falling
    // edge so that it sees what the rising edge has settled.
    task automatic wait_drained();
        while (sample_backlog.size() != 0 || s_valid || expected_writes.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Sender.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid        <= 1'b0;
            s_sample_value <= '0;
            send_gap       <= 0;
        end else begin
            if (s_valid && s_ready) expected_writes = {expected_writes, pack_sample(s_sample_value)};
            if (s_valid && !s_ready) begin
                // Request stays up unchanged until it is taken.
            end else if (send_gap != 0) begin
                send_gap <= send_gap - 1;
                s_valid  <= 1'b0;
            end else if (sample_backlog.size() != 0) begin
                s_valid        <= 1'b1;
                s_sample_value <= sample_backlog.pop_front();
                send_gap       <= sender_eager ? 0 : $urandom_range(0, 12);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Receiver and checker.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready      <= 1'b0;
            ready_hold   <= 0;
            stall_left   <= 0;
            stall_served <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    $display("%0t: unexpected descriptor, expected none, actual addr 0x%0h bits 0x%0h",
                             $time, m_line_address, m_packed_bits);
                    mismatches++;
                end else begin
                    head_write = expected_writes.pop_front();
                    check_field("line_address", head_write.line_address, m_line_address);
                    check_field("bit_offset", head_write.bit_offset, m_bit_offset);
                    check_field("bit_count", 32'(head_write.bit_count), 32'(m_bit_count));
                    check_field("packed_bits", head_write.packed_bits, m_packed_bits);
                    check_field("frame_done", 32'(head_write.frame_done), 32'(m_frame_done));
                end
            end
            if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                m_ready    <= 1'b0;
            end else if (stall_served != stall_requests) begin
                stall_served <= stall_served + 1;
                stall_left   <= LONG_STALL;
                m_ready      <= 1'b0;
            end else if (m_valid && m_ready) begin
                ready_draw = sink_eager ? 0 : $urandom_range(0, 12);
                ready_hold <= ready_draw;
                m_ready    <= (ready_draw == 0);
            end else if (ready_hold != 0) begin
                ready_hold <= ready_hold - 1;
                m_ready    <= (ready_hold == 1);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no request moved for %0d cycles", $time, idle_cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int phase_no;
        int count;
        phase_no = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset configuration, sample extremes including values above one.
        queue_sample(17'd0);
        queue_sample(17'd1);
        queue_sample(17'd32768);
        queue_sample(17'd65535);
        queue_sample(17'd65536);
        queue_sample(17'd65537);
        queue_sample(17'd131071);
        wait_drained();

        // Integer bits beyond the limit, two slots, full range, most negative
        // stride, even lines first over three block lines.
        write_reg(REG_SAMPLE_FORMAT, {50'd0, 2'd1, 6'd63, 6'd63});
        write_reg(REG_SLOT_OFFSETS, 64'hFFFF_8000_0001_0003);
        write_reg(REG_CONVERSION_RANGE, {30'd0, 17'd65536, 17'd0});
        write_reg(REG_PLANE_START, 64'hFFFF_FFFF);
        write_reg(REG_LINE_STRIDE, 64'h10_0000);
        write_reg(REG_BLOCK_STRIDE_BITS, 64'd65535);
        write_reg(REG_FRAME_GEOMETRY, {32'd0, 16'd3, 16'd1});
        write_reg(REG_INTERLEAVE_MODE, 64'(ILV_EVEN_FIRST));
        close_writes();
        queue_sample(17'd0);
        queue_sample(17'd65536);
        queue_sample(17'd32768);
        queue_sample(17'd1);
        queue_sample(17'd131071);
        queue_sample(17'd65535);
        queue_sample(17'd12345);
        wait_drained();

        // Fractional bits cut back to fit, reversed range, odd lines first.
        write_reg(REG_SAMPLE_FORMAT, {50'd0, 2'd0, 6'd30, 6'd20});
        write_reg(REG_CONVERSION_RANGE, {30'd0, 17'd16384, 17'd49152});
        write_reg(REG_LINE_STRIDE, 64'h0F_FFFF);
        write_reg(REG_FRAME_GEOMETRY, {32'd0, 16'd4, 16'd1});
        write_reg(REG_INTERLEAVE_MODE, 64'(ILV_ODD_FIRST));
        close_writes();
        queue_sample(17'd0);
        queue_sample(17'd65536);
        queue_sample(17'd16384);
        queue_sample(17'd131071);
        queue_sample(17'd40000);
        wait_drained();

        // No integer bits; mode three; zero geometry with the row counter
        // already past its new limit.
        write_reg(REG_SAMPLE_FORMAT, {50'd0, 2'd3, 6'd5, 6'd0});
        write_reg(REG_FRAME_GEOMETRY, 64'd0);
        write_reg(REG_INTERLEAVE_MODE, 64'd3);
        close_writes();
        queue_sample(17'd65536);
        queue_sample(17'd30000);
        queue_sample(17'd0);
        wait_drained();

        // A single bit with a range stuck at one.
        write_reg(REG_SAMPLE_FORMAT, {50'd0, 2'd0, 6'd0, 6'd1});
        write_reg(REG_CONVERSION_RANGE, {30'd0, 17'd65536, 17'd65536});
        close_writes();
        queue_sample(17'd0);
        queue_sample(17'd65536);
        wait_drained();

        while (queued_samples < TARGET_SAMPLES) begin
            phase_no++;
            if (phase_no == 1 || $urandom_range(0, 1))
                write_reg(REG_SAMPLE_FORMAT, random_reg_value(REG_SAMPLE_FORMAT));
            if (phase_no == 1 || $urandom_range(0, 1))
                write_reg(REG_SLOT_OFFSETS, random_reg_value(REG_SLOT_OFFSETS));
            if (phase_no == 1 || $urandom_range(0, 1))
                write_reg(REG_CONVERSION_RANGE, random_reg_value(REG_CONVERSION_RANGE));
            if (phase_no == 1 || $urandom_range(0, 1))
                write_reg(REG_PLANE_START, random_reg_value(REG_PLANE_START));
            if (phase_no == 1 || $urandom_range(0, 1))
                write_reg(REG_LINE_STRIDE, random_reg_value(REG_LINE_STRIDE));
            if (phase_no == 1 || $urandom_range(0, 1))
                write_reg(REG_BLOCK_STRIDE_BITS, random_reg_value(REG_BLOCK_STRIDE_BITS));
            if (phase_no == 1 || $urandom_range(0, 1))
                write_reg(REG_FRAME_GEOMETRY, random_reg_value(REG_FRAME_GEOMETRY));
            if (phase_no == 1 || $urandom_range(0, 1))
                write_reg(REG_INTERLEAVE_MODE, random_reg_value(REG_INTERLEAVE_MODE));
            close_writes();

            sender_eager = ($urandom_range(0, 3) == 0);
            sink_eager   = ($urandom_range(0, 3) == 0);
            count = $urandom_range(20, 90);
            repeat (count) queue_sample(random_sample());

            // Hold the result side off while requests keep coming, so the
            // block backs up into its input.
            if (phase_no % 8 == 3) begin
                sender_eager = 1'b1;
                stall_requests++;
            end
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

>>> files.f
src/psp_pkg.sv
src/pixel_sample_packer_top.sv
tb/sv/pixel_sample_packer_top_tb.sv
